// ===== design/vector_terminal_graph_decoder_core_assert.svh =====
// ----------------------------------------------------------------------------
// Vector terminal graph decoder assertion macros
// Shorthand for clocked assertions with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef VECTOR_TERMINAL_GRAPH_DECODER_CORE_ASSERT_SVH
`define VECTOR_TERMINAL_GRAPH_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define VTGD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vtgd assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define VTGD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vtgd assertion failed");

`endif

// ===== design/vtgd_pkg.sv =====
// ----------------------------------------------------------------------------
// Vector terminal graph decoder package
// Control codes, byte classes, field widths and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vtgd_pkg;

	localparam int BYTE_W = 8;
	localparam int PART_W = 5;
	localparam int COORD_W = 10;
	localparam int PX_W = 9;
	localparam int PY_W = 10;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	localparam logic [BYTE_W-1:0] CODE_GRAPH = 8'h1D;
	localparam logic [BYTE_W-1:0] CODE_ALPHA = 8'h1F;

	// Byte class taken from bits 6:5.
	localparam logic [1:0] CLS_NONE = 2'b00;
	localparam logic [1:0] CLS_HIGH = 2'b01;
	localparam logic [1:0] CLS_LOW_X = 2'b10;
	localparam logic [1:0] CLS_LOW_Y = 2'b11;

	localparam logic [PY_W-1:0] BOTTOM_RESET = 10'd399;

	// Register index, taken from the address above the byte offset.
	localparam logic [ADDR_W-3:0] REG_SCREEN_BOTTOM = 1'b0;

	typedef struct packed {
		logic plot_valid;
		logic join_line;
		logic [PX_W-1:0] from_x;
		logic [PY_W-1:0] from_y;
		logic [PX_W-1:0] to_x;
		logic [PY_W-1:0] to_y;
		logic in_graph_mode;
	} plot_t;

endpackage

// ===== design/vtgd_rx_if.sv =====
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready request channel carrying one terminal byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vtgd_rx_if;
	import vtgd_pkg::*;

	logic valid;
	logic ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== design/vtgd_plot_if.sv =====
// ----------------------------------------------------------------------------
// Plot result channel
// Valid/ready request channel carrying one decoded segment record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vtgd_plot_if;
	import vtgd_pkg::*;

	logic valid;
	logic ready;
	logic plot_valid;
	logic join_line;
	logic [PX_W-1:0] from_x;
	logic [PY_W-1:0] from_y;
	logic [PX_W-1:0] to_x;
	logic [PY_W-1:0] to_y;
	logic in_graph_mode;

	modport source (
		output valid, output plot_valid, output join_line, output from_x,
		output from_y, output to_x, output to_y, output in_graph_mode,
		input ready
	);
	modport sink (
		input valid, input plot_valid, input join_line, input from_x,
		input from_y, input to_x, input to_y, input in_graph_mode,
		output ready
	);
endinterface

// ===== design/vtgd_cfg.sv =====
// ----------------------------------------------------------------------------
// Vector terminal graph decoder configuration registers
// APB-style register port holding the screen bottom row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vtgd_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [vtgd_pkg::ADDR_W-1:0] paddr,
	input  logic [vtgd_pkg::DATA_W-1:0] pwdata,
	output logic [vtgd_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output logic [vtgd_pkg::PY_W-1:0]   screen_bottom
);
	import vtgd_pkg::*;

	logic [PY_W-1:0] bottom_q;
	logic            wr_en;
	logic            sel_bottom;

	assign pready = 1'b1;
	assign sel_bottom = (paddr[ADDR_W-1:2] == REG_SCREEN_BOTTOM);
	assign wr_en = psel && penable && pwrite && pready && sel_bottom;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bottom_q <= BOTTOM_RESET;
		end else if (wr_en) begin
			bottom_q <= pwdata[PY_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_bottom) begin
			prdata = {{(DATA_W-PY_W){1'b0}}, bottom_q};
		end
	end

	assign screen_bottom = bottom_q;
endmodule

// ===== design/vtgd_decode.sv =====
// ----------------------------------------------------------------------------
// Vector terminal graph decoder datapath
// Input byte register, mode and coordinate state, point scaling and the
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vtgd_decode (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [vtgd_pkg::PY_W-1:0] screen_bottom,
	vtgd_rx_if.sink                   rx,
	vtgd_plot_if.source               plot
);
	import vtgd_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] rx_byte_s1;

	logic [PART_W-1:0] high_y_q, high_x_q, low_y_q;
	logic              x_expected_q, pen_down_q, graph_q;
	logic [PX_W-1:0]   last_x_q;
	logic [PY_W-1:0]   last_y_q;

	logic [PART_W-1:0] high_y_nx, high_x_nx, low_y_nx;
	logic              x_expected_nx, pen_down_nx, graph_nx;
	logic [PX_W-1:0]   last_x_nx;
	logic [PY_W-1:0]   last_y_nx;

	logic              out_valid_q;
	plot_t             result_q;
	plot_t             result_nx;

	logic              adv;
	logic [PART_W-1:0] part;
	logic [1:0]        cls;
	logic [COORD_W-1:0] raw_x, raw_y;
	logic [PY_W-1:0]   half_y;
	logic [PX_W-1:0]   px;
	logic [PY_W-1:0]   py;

	assign adv = valid_s1 && (!out_valid_q || plot.ready);
	assign rx.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			rx_byte_s1 <= rx.rx_byte;
		end
	end

	assign part = rx_byte_s1[PART_W-1:0];
	assign cls = rx_byte_s1[6:5];
	assign raw_x = {high_x_q, part};
	assign raw_y = {high_y_q, low_y_q};
	assign half_y = {1'b0, raw_y[COORD_W-1:1]};
	assign px = raw_x[COORD_W-1:1];
	assign py = (half_y > screen_bottom) ? '0 : (screen_bottom - half_y);

	always_comb begin
		high_y_nx = high_y_q;
		high_x_nx = high_x_q;
		low_y_nx = low_y_q;
		x_expected_nx = x_expected_q;
		pen_down_nx = pen_down_q;
		graph_nx = graph_q;
		last_x_nx = last_x_q;
		last_y_nx = last_y_q;
		result_nx = '0;
		if (rx_byte_s1 == CODE_GRAPH) begin
			graph_nx = 1'b1;
			pen_down_nx = 1'b0;
			x_expected_nx = 1'b0;
		end else if (rx_byte_s1 == CODE_ALPHA) begin
			graph_nx = 1'b0;
		end else if (graph_q) begin
			unique case (cls)
				CLS_HIGH: begin
					if (x_expected_q) begin
						high_x_nx = part;
					end else begin
						high_y_nx = part;
					end
				end
				CLS_LOW_Y: begin
					low_y_nx = part;
					x_expected_nx = 1'b1;
				end
				CLS_LOW_X: begin
					result_nx.plot_valid = 1'b1;
					result_nx.join_line = pen_down_q;
					result_nx.from_x = pen_down_q ? last_x_q : px;
					result_nx.from_y = pen_down_q ? last_y_q : py;
					result_nx.to_x = px;
					result_nx.to_y = py;
					last_x_nx = px;
					last_y_nx = py;
					x_expected_nx = 1'b0;
					pen_down_nx = 1'b1;
				end
				default: begin
				end
			endcase
		end
		result_nx.in_graph_mode = graph_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_y_q <= '0;
			high_x_q <= '0;
			low_y_q <= '0;
			x_expected_q <= 1'b0;
			pen_down_q <= 1'b0;
			graph_q <= 1'b0;
			last_x_q <= '0;
			last_y_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				high_y_q <= high_y_nx;
				high_x_q <= high_x_nx;
				low_y_q <= low_y_nx;
				x_expected_q <= x_expected_nx;
				pen_down_q <= pen_down_nx;
				graph_q <= graph_nx;
				last_x_q <= last_x_nx;
				last_y_q <= last_y_nx;
				out_valid_q <= 1'b1;
			end else if (plot.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= result_nx;
		end
	end

	assign plot.valid = out_valid_q;
	assign plot.plot_valid = result_q.plot_valid;
	assign plot.join_line = result_q.join_line;
	assign plot.from_x = result_q.from_x;
	assign plot.from_y = result_q.from_y;
	assign plot.to_x = result_q.to_x;
	assign plot.to_y = result_q.to_y;
	assign plot.in_graph_mode = result_q.in_graph_mode;
endmodule

// ===== design/vector_terminal_graph_decoder_core.sv =====
// Path: an accepted byte passes the input register, then the result register, to
// its result record; the decode is a single pass of logic between them.
// Throughput: one byte per cycle while the result channel is not stalled.
// Reset: arst_n clears the mode, coordinate parts, pen state and last point, empties
// both registers and sets the screen bottom row to 399.
// ----------------------------------------------------------------------------
// Vector terminal graph decoder core
// Decodes a graph-mode terminal byte stream into scaled points and segments.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector_terminal_graph_decoder_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [vtgd_pkg::ADDR_W-1:0] paddr,
	input  logic [vtgd_pkg::DATA_W-1:0] pwdata,
	output logic [vtgd_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	vtgd_rx_if.sink                     rx,
	vtgd_plot_if.source                 plot
);
	import vtgd_pkg::*;

	logic [PY_W-1:0] screen_bottom;

	vtgd_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.screen_bottom (screen_bottom)
	);

	vtgd_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.screen_bottom (screen_bottom),
		.rx            (rx),
		.plot          (plot)
	);
endmodule

// ===== design/vtgd_checker.sv =====
// ----------------------------------------------------------------------------
// Vector terminal graph decoder port checker
// Watches the result channel of the core and is bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "vector_terminal_graph_decoder_core_assert.svh"

module vtgd_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      plot_valid,
	input logic                      join_line,
	input logic [vtgd_pkg::PX_W-1:0] from_x,
	input logic [vtgd_pkg::PY_W-1:0] from_y,
	input logic [vtgd_pkg::PX_W-1:0] to_x,
	input logic [vtgd_pkg::PY_W-1:0] to_y,
	input logic                      in_graph_mode
);
	import vtgd_pkg::*;

	logic  stalled;
	logic  point_out;
	logic  empty_out;
	logic  coords_zero;
	logic  lone_match;
	plot_t rec;

	assign stalled = out_valid && !out_ready;
	assign point_out = out_valid && plot_valid;
	assign empty_out = out_valid && !plot_valid;
	assign rec = {plot_valid, join_line, from_x, from_y, to_x, to_y, in_graph_mode};
	assign coords_zero = !join_line && from_x == '0 && from_y == '0 && to_x == '0
		&& to_y == '0;
	assign lone_match = from_x == to_x && from_y == to_y;

	`VTGD_ASSERT_NEXT(a_stall_hold, clk, arst_n, stalled, out_valid && $stable(rec))
	`VTGD_ASSERT_NOW(a_point_in_graph, clk, arst_n, point_out, in_graph_mode)
	`VTGD_ASSERT_NOW(a_empty_zero, clk, arst_n, empty_out, coords_zero)
	`VTGD_ASSERT_NOW(a_lone_point, clk, arst_n, point_out && !join_line, lone_match)
endmodule

bind vector_terminal_graph_decoder_core vtgd_checker u_vtgd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (plot.valid),
	.out_ready     (plot.ready),
	.plot_valid    (plot.plot_valid),
	.join_line     (plot.join_line),
	.from_x        (plot.from_x),
	.from_y        (plot.from_y),
	.to_x          (plot.to_x),
	.to_y          (plot.to_y),
	.in_graph_mode (plot.in_graph_mode)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// Vector terminal graph decoder core testbench
// Streams terminal bytes into the decoder with random gaps and output stalls,
// predicts every result record from its own copy of the decoder state, and
// checks each record field by field. The screen bottom register is written
// between phases, at its extremes and at random values.
// ----------------------------------------------------------------------------

module tb;
	import vtgd_pkg::*;

	localparam int CYCLE_LIMIT = 400_000;
	localparam int RANDOM_CHUNK = 320;
	localparam int RANDOM_CHUNKS = 4;
	localparam logic [ADDR_W-1:0] BOTTOM_ADDR = {REG_SCREEN_BOTTOM, 2'b00};

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	vtgd_rx_if rx_ch();
	vtgd_plot_if plot_ch();

	vector_terminal_graph_decoder_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.rx(rx_ch),
		.plot(plot_ch)
	);

	// Decoder state as the terminal stream defines it.
	logic [PART_W-1:0] hi_y_part = '0;
	logic [PART_W-1:0] hi_x_part = '0;
	logic [PART_W-1:0] lo_y_part = '0;
	logic x_pending = 1'b0;
	logic pen_down = 1'b0;
	logic graph_on = 1'b0;
	logic [PX_W-1:0] last_x = '0;
	logic [PY_W-1:0] last_y = '0;
	logic [PY_W-1:0] screen_bottom = BOTTOM_RESET;

	plot_t pending_plots[$];
	bit quiet_tail = 1'b0;
	int unsigned errors = 0;
	int unsigned bytes_sent = 0;
	int unsigned records_seen = 0;
	int unsigned points_seen = 0;
	int unsigned lines_seen = 0;
	int unsigned bottom_writes = 0;
	int unsigned cycle_count = 0;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic plot_t decode_byte(input logic [BYTE_W-1:0] b);
		plot_t r;
		logic [COORD_W-1:0] raw_x;
		logic [COORD_W-1:0] raw_y;
		logic [PX_W-1:0] px;
		logic [PY_W-1:0] half_y;
		logic [PY_W-1:0] py;
		r = '0;
		if (b == CODE_GRAPH) begin
			graph_on = 1'b1;
			pen_down = 1'b0;
			x_pending = 1'b0;
		end else if (b == CODE_ALPHA) begin
			graph_on = 1'b0;
		end else if (graph_on) begin
			case (b[6:5])
				CLS_HIGH: begin
					if (x_pending) begin
						hi_x_part = b[PART_W-1:0];
					end else begin
						hi_y_part = b[PART_W-1:0];
					end
				end
				CLS_LOW_Y: begin
					lo_y_part = b[PART_W-1:0];
					x_pending = 1'b1;
				end
				CLS_LOW_X: begin
					raw_x = {hi_x_part, b[PART_W-1:0]};
					raw_y = {hi_y_part, lo_y_part};
					px = raw_x[COORD_W-1:1];
					half_y = {1'b0, raw_y[COORD_W-1:1]};
					py = (half_y > screen_bottom) ? '0 : screen_bottom - half_y;
					r.plot_valid = 1'b1;
					r.join_line = pen_down;
					r.from_x = pen_down ? last_x : px;
					r.from_y = pen_down ? last_y : py;
					r.to_x = px;
					r.to_y = py;
					last_x = px;
					last_y = py;
					x_pending = 1'b0;
					pen_down = 1'b1;
				end
				default: begin
				end
			endcase
		end
		r.in_graph_mode = graph_on;
		return r;
	endfunction

	function automatic logic [BYTE_W-1:0] coord_byte(input logic [1:0] cls);
		logic [BYTE_W-1:0] b;
		b = {1'($urandom_range(0, 1)), cls, 5'($urandom_range(0, 31))};
		return b;
	endfunction

	task automatic report_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int unsigned gap;
		@(negedge clk);
		rx_ch.valid = 1'b1;
		rx_ch.rx_byte = b;
		do @(posedge clk); while (!rx_ch.ready);
		pending_plots.push_back(decode_byte(b));
		bytes_sent++;
		if (!quiet_tail && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 17);
			@(negedge clk);
			rx_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic wait_for_plots();
		@(negedge clk);
		rx_ch.valid = 1'b0;
		while (pending_plots.size() != 0) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = addr;
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic check_screen_bottom();
		logic [DATA_W-1:0] rd;
		apb_access(1'b0, BOTTOM_ADDR, '0, rd);
		report_field("screen_bottom readback", DATA_W'(screen_bottom), rd);
	endtask

	task automatic set_screen_bottom(input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] rd;
		wait_for_plots();
		repeat (4) @(posedge clk);
		apb_access(1'b1, BOTTOM_ADDR, value, rd);
		screen_bottom = value[PY_W-1:0];
		bottom_writes++;
		check_screen_bottom();
	endtask

	task automatic send_stroke();
		if ($urandom_range(0, 1)) begin
			send_byte(coord_byte(CLS_HIGH));
		end
		if ($urandom_range(0, 3) != 0) begin
			send_byte(coord_byte(CLS_LOW_Y));
			if ($urandom_range(0, 2) != 0) begin
				send_byte(coord_byte(CLS_HIGH));
			end
		end
		send_byte(coord_byte(CLS_LOW_X));
	endtask

	task automatic test_reset_state();
		check_screen_bottom();
		send_byte(8'h41);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h7E);
	endtask

	task automatic test_directed_stream();
		logic [BYTE_W-1:0] seq[] = '{
			CODE_GRAPH, 8'h3F, 8'h7F, 8'h3F, 8'h5F,
			8'h20, 8'h60, 8'h20, 8'h40,
			8'h00, 8'h9D, 8'h1E, 8'h80,
			8'hB0, 8'hC8,
			CODE_GRAPH, CODE_GRAPH, 8'hEA, 8'h4F,
			CODE_ALPHA, 8'h45, CODE_ALPHA
		};
		foreach (seq[i]) begin
			send_byte(seq[i]);
		end
	endtask

	task automatic test_screen_bottom_extremes();
		logic [DATA_W-1:0] settings[] = '{32'd0, 32'd1023, 32'hFFFF_FC01, 32'd512};
		foreach (settings[i]) begin
			set_screen_bottom(settings[i]);
			send_byte(CODE_GRAPH);
			send_byte(8'h3F);
			send_byte(8'h7F);
			send_byte(8'h20);
			send_byte(8'h5F);
			send_byte(8'h20);
			send_byte(8'h60);
			send_byte(8'h40);
			repeat (6) send_stroke();
		end
	endtask

	task automatic test_random_stream();
		int unsigned chunk_start;
		int unsigned pick;
		for (int c = 0; c < RANDOM_CHUNKS; c++) begin
			set_screen_bottom($urandom());
			quiet_tail = (c == RANDOM_CHUNKS - 1);
			chunk_start = bytes_sent;
			send_byte(CODE_GRAPH);
			while (bytes_sent - chunk_start < RANDOM_CHUNK) begin
				pick = $urandom_range(0, 19);
				if (pick < 14) begin
					send_stroke();
				end else if (pick < 17) begin
					send_byte(8'($urandom_range(0, 255)));
				end else if (pick < 19) begin
					send_byte(CODE_GRAPH);
				end else begin
					send_byte(CODE_ALPHA);
				end
			end
		end
	endtask

	initial begin
		int unsigned burst;
		plot_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 17);
				plot_ch.ready = 1'b0;
				repeat (burst - 1) @(negedge clk);
			end else begin
				plot_ch.ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		plot_t want;
		if (arst_n && plot_ch.valid && plot_ch.ready) begin
			records_seen++;
			if (plot_ch.plot_valid === 1'b1) begin
				points_seen++;
				if (plot_ch.join_line === 1'b1) begin
					lines_seen++;
				end
			end
			if (pending_plots.size() == 0) begin
				errors++;
				$display("%0t: unexpected record, expected none, actual %p", $time,
					plot_t'({plot_ch.plot_valid, plot_ch.join_line, plot_ch.from_x,
					plot_ch.from_y, plot_ch.to_x, plot_ch.to_y, plot_ch.in_graph_mode}));
			end else begin
				want = pending_plots.pop_front();
				report_field("plot_valid", DATA_W'(want.plot_valid), DATA_W'(plot_ch.plot_valid));
				report_field("join_line", DATA_W'(want.join_line), DATA_W'(plot_ch.join_line));
				report_field("from_x", DATA_W'(want.from_x), DATA_W'(plot_ch.from_x));
				report_field("from_y", DATA_W'(want.from_y), DATA_W'(plot_ch.from_y));
				report_field("to_x", DATA_W'(want.to_x), DATA_W'(plot_ch.to_x));
				report_field("to_y", DATA_W'(want.to_y), DATA_W'(plot_ch.to_y));
				report_field("in_graph_mode", DATA_W'(want.in_graph_mode),
					DATA_W'(plot_ch.in_graph_mode));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d records outstanding.", cycle_count,
				pending_plots.size());
			$display("FAIL vector_terminal_graph_decoder_core");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_directed_stream();
		test_screen_bottom_extremes();
		test_random_stream();

		wait_for_plots();
		repeat (10) @(posedge clk);
		if (pending_plots.size() != 0) begin
			errors++;
			$display("%0t: %0d expected records never arrived", $time, pending_plots.size());
		end
		$display("Sent %0d bytes and checked %0d records: %0d points, %0d joined lines.",
			bytes_sent, records_seen, points_seen, lines_seen);
		$display("Screen bottom was rewritten %0d times; %0d mismatches found.",
			bottom_writes, errors);
		if (errors == 0) begin
			$display("PASS vector_terminal_graph_decoder_core");
		end else begin
			$display("FAIL vector_terminal_graph_decoder_core");
		end
		$finish;
	end
endmodule
